### hw/rtl/hmca_pkg.sv
// hmca_pkg: shared types and constants for the hashed material cache.
// No dependencies.
`timescale 1ns / 1ps

package hmca_pkg;

	localparam logic [63:0] HASH_INIT = 64'hCBF29CE484222325;
	localparam logic [63:0] HASH_MUL  = 64'h00000100000001B3;

	typedef enum logic [3:0] {
		ST_OFF         = 4'd0,
		ST_NOSOURCE    = 4'd1,
		ST_TARGET      = 4'd2,
		ST_HIT         = 4'd3,
		ST_CREATED     = 4'd4,
		ST_DEFERRED    = 4'd5,
		ST_QUARANTINED = 4'd6,
		ST_FULL        = 4'd7,
		ST_BEGUN       = 4'd8,
		ST_REAPDONE    = 4'd9,
		ST_EVICTED     = 4'd10
	} status_t;

	typedef enum logic [1:0] {
		CMD_BIND  = 2'd0,
		CMD_BEGIN = 2'd1,
		CMD_REAP  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_BUDGET = 2'd1;
	localparam logic [1:0] REG_IDLE   = 2'd2;
	localparam logic [1:0] REG_MESH   = 2'd3;

	localparam int CFG_W = 20;

endpackage

### hw/rtl/hashed_material_cache_with_aging_core.sv
// Channel | dir | handshake         | payload
// in      | in  | in_valid/in_stall | cmd, key_word0..4, source flags, frame_number, create_ok
// out     | out | out_valid/out_stall | status, digest, slot_index, release_needed, last_result
// cfg     | in  | cfg_we            | cfg_index, cfg_data
// Bind: min(KEY_WORDS, 5)*8 byte steps, each a 64-bit multiply by the prime done as
// x<<40 plus x<<8 plus x*0xB3 (states HBYTE, HMUL, HSUM), then one memory read per
// slot of a sequential scan. Reap: one slot at a time; each eviction after the first
// re-reads its slot, and a stalled output adds waits. Begin frame: reloads the budget.
// Reset: valid bits are flip-flops cleared at once; no clearing pass.
// A stalled output holds the scan; input is taken only when idle.
// Depends on hmca_pkg, hmca_ram.
`timescale 1ns / 1ps

module hashed_material_cache_with_aging_core #(
	parameter int TABLE_ENTRIES = 64,
	parameter int KEY_WORDS     = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [63:0] key_word0,
	input  logic [63:0] key_word1,
	input  logic [63:0] key_word2,
	input  logic [63:0] key_word3,
	input  logic [63:0] key_word4,
	input  logic        source_present,
	input  logic        source_from_target,
	input  logic [31:0] frame_number,
	input  logic        create_ok,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [63:0] digest,
	output logic [5:0]  slot_index,
	output logic        release_needed,
	output logic        last_result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [hmca_pkg::CFG_W-1:0] cfg_data
);
	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int NW = (KEY_WORDS < 5) ? KEY_WORDS : 5;
	localparam int KB = NW * 64;
	localparam int BW = $clog2(NW * 8 + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_HBYTE, S_HMUL, S_HSUM, S_LREAD, S_LCHK, S_CREATE,
		S_RREAD, S_RCHK, S_OUT
	} state_t;

	state_t state_q;
	logic        en_q;
	logic [15:0] budget_cfg_q, budget_left_q;
	logic [19:0] idle_q, mesh_q;

	logic [KB-1:0] key_q;
	logic [BW-1:0] bytes_q;
	logic [63:0]   hash_q, xm_q;
	logic [31:0]   frame_q;
	logic          ok_q;
	logic [AW:0]   scan_q;
	logic          free_found_q;
	logic [AW-1:0] free_slot_q;
	logic [32:0]   cutoff_q;
	logic          any_evict_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [96:0]   ram_wdata, ram_rdata;

	logic [3:0]  st_q;
	logic [63:0] oh_q;
	logic [5:0]  os_q;
	logic        orel_q, olast_q;
	state_t      ret_q;

	logic [KB-1:0] key_in;
	logic [20:0]   safe;
	logic          idx_ok;

	hmca_ram #(.WIDTH(97), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	always_comb begin
		logic [319:0] all;
		all = {key_word4, key_word3, key_word2, key_word1, key_word0};
		key_in = all[KB-1:0];
		safe = {1'b0, mesh_q} + 21'd1;
		if ({1'b0, idle_q} > safe) begin
			safe = {1'b0, idle_q};
		end
	end

	assign idx_ok = (scan_q < (AW+1)'(TABLE_ENTRIES));
	assign ram_addr = (state_q == S_CREATE) ? free_slot_q : scan_q[AW-1:0];
	assign ram_we = (state_q == S_CREATE);
	assign ram_wdata = {~ok_q, frame_q, hash_q};

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status = st_q;
	assign digest = oh_q;
	assign slot_index = os_q;
	assign release_needed = orel_q;
	assign last_result = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			en_q <= 1'b1;
			budget_cfg_q <= 16'd32;
			idle_q <= 20'd600;
			mesh_q <= 20'd120;
			budget_left_q <= '0;
			valid_q <= '0;
			ret_q <= S_IDLE;
			st_q <= hmca_pkg::ST_OFF;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					hmca_pkg::REG_ENABLE: en_q <= cfg_data[0];
					hmca_pkg::REG_BUDGET: budget_cfg_q <= cfg_data[15:0];
					hmca_pkg::REG_IDLE:   idle_q <= cfg_data[19:0];
					hmca_pkg::REG_MESH:   mesh_q <= cfg_data[19:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						key_q <= key_in;
						frame_q <= frame_number;
						ok_q <= create_ok;
						hash_q <= hmca_pkg::HASH_INIT;
						bytes_q <= '0;
						scan_q <= '0;
						free_found_q <= 1'b0;
						free_slot_q <= '0;
						any_evict_q <= 1'b0;
						oh_q <= '0;
						os_q <= '0;
						orel_q <= 1'b0;
						olast_q <= 1'b1;
						ret_q <= S_IDLE;
						unique case (hmca_pkg::cmd_t'(cmd))
							hmca_pkg::CMD_BIND: begin
								if (!en_q) begin
									st_q <= hmca_pkg::ST_OFF; state_q <= S_OUT;
								end else if (!source_present) begin
									st_q <= hmca_pkg::ST_NOSOURCE; state_q <= S_OUT;
								end else if (source_from_target) begin
									st_q <= hmca_pkg::ST_TARGET; state_q <= S_OUT;
								end else begin
									state_q <= S_HBYTE;
								end
							end
							hmca_pkg::CMD_BEGIN: begin
								budget_left_q <= budget_cfg_q;
								st_q <= hmca_pkg::ST_BEGUN;
								state_q <= S_OUT;
							end
							hmca_pkg::CMD_REAP: begin
								if ({1'b0, frame_number} < {12'd0, safe}) begin
									st_q <= hmca_pkg::ST_REAPDONE; state_q <= S_OUT;
								end else begin
									cutoff_q <= {1'b0, frame_number} - {12'd0, safe};
									state_q <= S_RREAD;
								end
							end
							default: ;
						endcase
					end
				end
				S_HBYTE: begin
					// xor next byte, then multiply serially by the prime
					xm_q <= hash_q ^ {56'd0, key_q[7:0]};
					key_q <= key_q >> 8;
					bytes_q <= bytes_q + BW'(1);
					state_q <= S_HMUL;
				end
				S_HMUL: begin
					// prime = 2^40 + 2^8 + 0xB3: add x<<40 and x<<8 terms
					hash_q <= (xm_q << 40) + (xm_q << 8);
					state_q <= S_HSUM;
				end
				S_HSUM: begin
					hash_q <= hash_q + (xm_q * 64'hB3);
					if (bytes_q == BW'(NW * 8)) begin
						state_q <= S_LREAD;
					end else begin
						state_q <= S_HBYTE;
					end
				end
				S_LREAD: begin
					if (hash_q == '0) begin
						hash_q <= 64'd1;
					end
					oh_q <= (hash_q == '0) ? 64'd1 : hash_q;
					if (idx_ok) begin
						state_q <= S_LCHK;
					end else begin
						os_q <= '0;
						if (budget_left_q == '0) begin
							st_q <= hmca_pkg::ST_DEFERRED; state_q <= S_OUT;
						end else if (!free_found_q) begin
							st_q <= hmca_pkg::ST_FULL; state_q <= S_OUT;
						end else begin
							state_q <= S_CREATE;
						end
					end
				end
				S_LCHK: begin
					if (valid_q[scan_q[AW-1:0]] && ram_rdata[63:0] == hash_q) begin
						st_q <= ram_rdata[96] ? hmca_pkg::ST_QUARANTINED : hmca_pkg::ST_HIT;
						os_q <= 6'(scan_q[AW-1:0]);
						free_slot_q <= scan_q[AW-1:0];
						ok_q <= ~ram_rdata[96];
						hash_q <= ram_rdata[63:0];
						state_q <= S_CREATE;
						ret_q <= S_OUT;
					end else begin
						if (!valid_q[scan_q[AW-1:0]] && !free_found_q) begin
							free_found_q <= 1'b1;
							free_slot_q <= scan_q[AW-1:0];
						end
						scan_q <= scan_q + (AW+1)'(1);
						state_q <= S_LREAD;
					end
				end
				S_CREATE: begin
					// writes entry (new, or hit restamp with same hash/failed)
					valid_q[free_slot_q] <= 1'b1;
					state_q <= S_OUT;
					if (ret_q == S_IDLE) begin
						os_q <= 6'(free_slot_q);
						if (ok_q) begin
							budget_left_q <= budget_left_q - 16'd1;
							st_q <= hmca_pkg::ST_CREATED;
						end else begin
							st_q <= hmca_pkg::ST_QUARANTINED;
						end
					end
					ret_q <= S_IDLE;
				end
				S_RREAD: begin
					if (idx_ok) begin
						state_q <= S_RCHK;
					end else if (!any_evict_q) begin
						st_q <= hmca_pkg::ST_REAPDONE;
						oh_q <= '0; os_q <= '0; orel_q <= 1'b0; olast_q <= 1'b1;
						ret_q <= S_IDLE;
						state_q <= S_OUT;
					end else begin
						// held eviction is the final beat
						olast_q <= 1'b1;
						ret_q <= S_IDLE;
						state_q <= S_OUT;
					end
				end
				S_RCHK: begin
					state_q <= S_RREAD;
					if (valid_q[scan_q[AW-1:0]] && {1'b0, ram_rdata[95:64]} <= cutoff_q) begin
						if (any_evict_q) begin
							// send the held eviction, then revisit this slot
							any_evict_q <= 1'b0;
							ret_q <= S_RREAD;
							state_q <= S_OUT;
						end else begin
							valid_q[scan_q[AW-1:0]] <= 1'b0;
							any_evict_q <= 1'b1;
							st_q <= hmca_pkg::ST_EVICTED;
							oh_q <= ram_rdata[63:0];
							os_q <= 6'(scan_q[AW-1:0]);
							orel_q <= ~ram_rdata[96];
							olast_q <= 1'b0;
							scan_q <= scan_q + (AW+1)'(1);
						end
					end else begin
						scan_q <= scan_q + (AW+1)'(1);
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/hmca_ram.sv
// hmca_ram: generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module hmca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
